/* rtl/chd_pkg.sv */
// Shared types and constants for the canonical Huffman decoder.
package chd_pkg;

    localparam int MaxCodeLen = 31;
    localparam int ResultCap  = 32;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_STREAM = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_CHECK,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MIN_LEN  = 2'd0;
    localparam logic [1:0] REG_MAX_LEN  = 2'd1;
    localparam logic [1:0] REG_SYM_CNT  = 2'd2;

    typedef struct packed {
        logic load_count;
        logic build_start;
        logic build_step;
        logic append;
        logic search;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic build_done;
        logic more;
        logic slot_free;
    } status_t;

endpackage

/* rtl/chd_ctrl.sv */
// Controller state machine for the canonical Huffman decoder.
module chd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       operation,
    input  chd_pkg::status_t status,
    output chd_pkg::cmd_t    cmd,
    output logic             in_stall,
    output chd_pkg::state_t  state
);
    import chd_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(operation))
                        OP_LOAD:   cmd.load_count = 1'b1;
                        OP_BUILD:
                        begin
                            cmd.build_start = 1'b1;
                            state_next      = ST_BUILD;
                        end
                        OP_STREAM:
                        begin
                            cmd.append = 1'b1;
                            state_next = ST_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUILD:
            begin
                cmd.build_step = 1'b1;
                if (status.build_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                state_next = status.more ? ST_SEARCH : ST_IDLE;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign state    = state_reg;

endmodule

/* rtl/chd_datapath.sv */
// Datapath: code tables, bit buffer, length search and output register.
module chd_datapath #(
    parameter int MAX_CODE_LEN = chd_pkg::MaxCodeLen,
    parameter int LW           = $clog2(MAX_CODE_LEN + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  chd_pkg::cmd_t    cmd,
    output chd_pkg::status_t status,
    input  logic [LW-1:0]    lo,
    input  logic [LW-1:0]    hi,
    input  logic [31:0]      symbol_count,
    input  logic [LW-1:0]    load_index,
    input  logic [31:0]      code_count,
    input  logic [31:0]      stream_word,
    output logic [31:0]      symbol,
    output logic             run_last,
    output logic             message_last,
    output logic             out_valid,
    input  logic             out_stall
);
    import chd_pkg::*;

    localparam int Depth = MAX_CODE_LEN + 1;
    localparam logic [32:0] FullLimit = 33'h1_0000_0000;

    logic [31:0] cnt_reg [Depth];
    logic [31:0] off_reg [Depth];
    logic [32:0] lim_reg [Depth];

    logic [63:0]   buf_reg;
    logic [6:0]    bits_reg;
    logic [31:0]   emitted_reg;
    logic [5:0]    n_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] bi_reg;
    logic [32:0]   aligned_reg;
    logic [31:0]   first_reg;

    logic [31:0] sym_reg;
    logic        rl_reg, ml_reg, ovalid_reg;

    logic [31:0] window;
    assign window = buf_reg[63:32];

    // Build step arithmetic
    logic [5:0]  sh;
    logic [31:0] first_code;
    logic [63:0] lim_sum;
    logic [32:0] lim_sat;
    assign sh         = 6'd32 - 6'(bi_reg);
    assign first_code = 32'(aligned_reg >> sh);
    assign lim_sum    = {31'd0, aligned_reg} + ({32'd0, cnt_reg[bi_reg]} << sh);
    assign lim_sat    = (lim_sum > 64'(FullLimit)) ? FullLimit : lim_sum[32:0];
    assign status.build_done = (bi_reg == hi);

    // Length search: shortest length whose limit exceeds the window
    logic [LW-1:0] found_len;
    always_comb
    begin
        found_len = hi;
        for (int l = MAX_CODE_LEN; l >= 1; l--)
        begin
            if ((LW'(l) >= lo) && (LW'(l) < hi) && ({1'b0, window} < lim_reg[l]))
            begin
                found_len = LW'(l);
            end
        end
    end

    // Emit arithmetic
    logic [31:0] code, sym_val, emitted_inc;
    logic [6:0]  bits_left;
    logic [5:0]  n_inc;
    assign code        = window >> (6'd32 - 6'(len_reg));
    assign sym_val     = code + off_reg[len_reg];
    assign bits_left   = bits_reg - 7'(len_reg);
    assign emitted_inc = emitted_reg + 32'd1;
    assign n_inc       = n_reg + 6'd1;

    assign status.more = (n_reg < 6'(ResultCap)) && (bits_reg >= 7'(hi))
                       && (emitted_reg < symbol_count);
    assign status.slot_free = !ovalid_reg || !out_stall;

    // Count table, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Depth; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.load_count)
        begin
            cnt_reg[load_index] <= code_count;
        end
    end

    // Offset and limit tables
    always_ff @(posedge clk)
    begin
        if (cmd.build_step)
        begin
            off_reg[bi_reg] <= first_reg - first_code;
            lim_reg[bi_reg] <= status.build_done ? FullLimit : lim_sat;
        end
    end

    // Build walk and search result
    always_ff @(posedge clk)
    begin
        if (cmd.build_start)
        begin
            bi_reg      <= lo;
            aligned_reg <= '0;
            first_reg   <= '0;
        end
        else if (cmd.build_step)
        begin
            bi_reg      <= bi_reg + LW'(1);
            aligned_reg <= lim_sat;
            first_reg   <= first_reg + cnt_reg[bi_reg];
        end
        if (cmd.search)
        begin
            len_reg <= found_len;
        end
    end

    // Bit buffer and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            bits_reg    <= '0;
            emitted_reg <= '0;
            n_reg       <= '0;
        end
        else if (cmd.build_step && status.build_done)
        begin
            buf_reg     <= '0;
            bits_reg    <= '0;
            emitted_reg <= '0;
        end
        else if (cmd.append)
        begin
            n_reg <= '0;
            if (bits_reg <= 7'd32)
            begin
                buf_reg  <= buf_reg | ({32'd0, stream_word} << (7'd32 - bits_reg));
                bits_reg <= bits_reg + 7'd32;
            end
        end
        else if (cmd.emit)
        begin
            buf_reg     <= buf_reg << len_reg;
            bits_reg    <= bits_left;
            emitted_reg <= emitted_inc;
            n_reg       <= n_inc;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            sym_reg <= sym_val;
            ml_reg  <= (emitted_inc == symbol_count);
            rl_reg  <= !((n_inc < 6'(ResultCap)) && (bits_left >= 7'(hi))
                       && (emitted_inc < symbol_count));
        end
    end

    assign symbol       = sym_reg;
    assign run_last     = rl_reg;
    assign message_last = ml_reg;
    assign out_valid    = ovalid_reg;

endmodule

/* rtl/canonical_huffman_decoder.sv */
// A stream request passes the check, limit search and emit states before out_valid rises.
// Each symbol passes the check, limit search and emit states in turn; up to 32 per word.
// Load requests complete in idle; a build stalls while it walks clamped min_len to max_len.
// Output register lets the next symbol be worked on while one waits.
// Reset (rst_n, async low): counts, buffer and counters clear; bounds 1/16.
// Top level: canonical Huffman decoder with APB configuration.
module canonical_huffman_decoder #(
    parameter int MAX_CODE_LEN = chd_pkg::MaxCodeLen
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [4:0]  length_index,
    input  logic [31:0] code_count,
    input  logic [31:0] stream_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] symbol,
    output logic        run_last,
    output logic        message_last
);
    import chd_pkg::*;

    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    logic [4:0]  min_len_reg, max_len_reg;
    logic [31:0] sym_cnt_reg;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= 5'd1;
            max_len_reg <= 5'd16;
            sym_cnt_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_MIN_LEN: min_len_reg <= pwdata[4:0];
                REG_MAX_LEN: max_len_reg <= pwdata[4:0];
                REG_SYM_CNT: sym_cnt_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MIN_LEN: prdata = {27'd0, min_len_reg};
            REG_MAX_LEN: prdata = {27'd0, max_len_reg};
            REG_SYM_CNT: prdata = sym_cnt_reg;
            default:     prdata = '0;
        endcase
    end

    // Effective length bounds
    logic [4:0] hi5, lo5;
    always_comb
    begin
        hi5 = max_len_reg;
        if (hi5 < 5'd1)
        begin
            hi5 = 5'd1;
        end
        if (hi5 > 5'(MAX_CODE_LEN))
        begin
            hi5 = 5'(MAX_CODE_LEN);
        end
        lo5 = (min_len_reg < 5'd1) ? 5'd1 : min_len_reg;
        if (lo5 > hi5)
        begin
            lo5 = hi5;
        end
    end

    // Loads with an index outside 1 to MAX_CODE_LEN are dropped
    logic   idx_ok;
    cmd_t   cmd, dp_cmd;
    status_t status;
    state_t  state;
    assign idx_ok = (length_index >= 5'd1) && (length_index <= 5'(MAX_CODE_LEN));

    always_comb
    begin
        dp_cmd            = cmd;
        dp_cmd.load_count = cmd.load_count && idx_ok;
    end

    chd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .state     (state)
    );

    chd_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .LW           (LW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (status),
        .lo           (LW'(lo5)),
        .hi           (LW'(hi5)),
        .symbol_count (sym_cnt_reg),
        .load_index   (LW'(length_index)),
        .code_count   (code_count),
        .stream_word  (stream_word),
        .symbol       (symbol),
        .run_last     (run_last),
        .message_last (message_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

    // A symbol is only written into a free output slot
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.slot_free)
        else $error("symbol emitted over a pending result");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("conflicting datapath commands");

    // New requests are taken only while idle
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (state == ST_IDLE))
        else $error("request taken outside idle");

    // An emit always fills the output register
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("emitted symbol not presented");

endmodule

/* dv/tb_canonical_huffman_decoder.sv */
// Self-checking testbench for the canonical Huffman decoder: table loads, builds and decode.
`timescale 1ns / 100ps

module tb_canonical_huffman_decoder;
    import chd_pkg::*;

    localparam int IdleWait   = 200;
    localparam int StallLimit = 5000;

    typedef struct {
        op_t         op;
        logic [4:0]  idx;
        logic [31:0] cnt;
        logic [31:0] word;
    } request_t;

    typedef struct {
        logic [31:0] sym;
        logic        rl;
        logic        ml;
    } symbol_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  operation = '0;
    logic [4:0]  length_index = '0;
    logic [31:0] code_count = '0;
    logic [31:0] stream_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] symbol;
    logic        run_last;
    logic        message_last;

    canonical_huffman_decoder dut (.*);

    // Decoder shadow state
    logic [4:0]  sh_min = 5'd1;
    logic [4:0]  sh_max = 5'd16;
    logic [31:0] sh_symcnt = '0;
    logic [31:0] len_count [32];
    logic [31:0] len_offset [32];
    logic [32:0] len_limit [32];
    logic [63:0] bitbuf = '0;
    int          bitcnt = 0;
    logic [31:0] emitted = '0;

    request_t    pending_q [$];
    symbol_rec_t symbol_q [$];
    int          errors = 0;
    int          seen = 0;
    int          quiet = 0;
    logic        hold_done = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        for (int i = 0; i < 32; i++) len_count[i] = '0;
    end

    function automatic void length_bounds(input logic [4:0] mn, input logic [4:0] mx,
                                          output int lo, output int hi);
        hi = mx;
        lo = mn;
        if (hi < 1) hi = 1;
        if (hi > MaxCodeLen) hi = MaxCodeLen;
        if (lo < 1) lo = 1;
        if (lo > hi) lo = hi;
    endfunction

    // Apply one accepted request to the shadow state and queue its symbols
    task automatic decode_request(input request_t r);
        int lo, hi, n, len, sh;
        logic [63:0] aligned, lim;
        logic [31:0] first_sym, window, code;
        symbol_rec_t s;
        n = 0;
        length_bounds(sh_min, sh_max, lo, hi);
        case (r.op)
            OP_LOAD: if (r.idx >= 1 && r.idx <= MaxCodeLen) len_count[r.idx] = r.cnt;
            OP_BUILD: begin
                aligned = '0;
                first_sym = '0;
                for (int i = lo; i <= hi; i++) begin
                    sh = 32 - i;
                    code = 32'(aligned >> sh);
                    lim = aligned + ({32'b0, len_count[i]} << sh);
                    if (lim > 64'h1_0000_0000) lim = 64'h1_0000_0000;
                    len_offset[i] = first_sym - code;
                    len_limit[i] = (i == hi) ? 33'h1_0000_0000 : lim[32:0];
                    aligned = lim;
                    first_sym += len_count[i];
                end
                bitbuf = '0;
                bitcnt = 0;
                emitted = '0;
            end
            OP_STREAM: begin
                // Word is dropped when the buffer already holds more than 32 bits
                if (bitcnt <= 32) begin
                    bitbuf |= {32'b0, r.word} << (32 - bitcnt);
                    bitcnt += 32;
                end
                while (n < ResultCap && bitcnt >= hi && emitted < sh_symcnt) begin
                    window = bitbuf[63:32];
                    len = lo;
                    while (len < hi && {1'b0, window} >= len_limit[len]) len++;
                    code = window >> (32 - len);
                    bitbuf <<= len;
                    bitcnt -= len;
                    emitted++;
                    s.sym = code + len_offset[len];
                    s.rl = 1'b0;
                    s.ml = (emitted == sh_symcnt);
                    symbol_q.push_back(s);
                    n++;
                end
                if (n > 0) symbol_q[symbol_q.size() - 1].rl = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Driver: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        request_t r;
        logic take;
        if (rst_n) begin
            take = in_valid && !in_stall;
            if (take) begin
                r.op = op_t'(operation);
                r.idx = length_index;
                r.cnt = code_count;
                r.word = stream_word;
                decode_request(r);
            end
            if (!in_valid || take) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    r = pending_q.pop_front();
                    in_valid <= 1'b1;
                    operation <= r.op;
                    length_index <= r.idx;
                    code_count <= r.cnt;
                    stream_word <= r.word;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall pattern, one long hold-off, field compare
    int stall_mode = 0;
    int hold_left = 0;
    always @(posedge clk) begin
        symbol_rec_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                seen++;
                if (symbol_q.size() == 0) begin
                    $error("unexpected symbol %h", symbol);
                    errors++;
                end else begin
                    e = symbol_q.pop_front();
                    if (symbol !== e.sym) begin
                        $error("symbol exp %h got %h", e.sym, symbol);
                        errors++;
                    end
                    if (run_last !== e.rl) begin
                        $error("run_last exp %b got %b", e.rl, run_last);
                        errors++;
                    end
                    if (message_last !== e.ml) begin
                        $error("message_last exp %b got %b", e.ml, message_last);
                        errors++;
                    end
                end
            end
            if (!hold_done && seen == 60) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= StallLimit) begin
            $display("tb_canonical_huffman_decoder: errors");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] regidx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regidx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (regidx)
            REG_MIN_LEN: sh_min = val[4:0];
            REG_MAX_LEN: sh_max = val[4:0];
            default:     sh_symcnt = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || symbol_q.size() != 0) @(posedge clk);
        repeat (IdleWait) @(posedge clk);
    endtask

    task automatic configure(input logic [4:0] mn, input logic [4:0] mx, input logic [31:0] sc);
        wait_idle();
        apb_write(REG_MIN_LEN, {27'b0, mn});
        apb_write(REG_MAX_LEN, {27'b0, mx});
        apb_write(REG_SYM_CNT, sc);
    endtask

    task automatic push_req(input op_t op, input logic [4:0] idx, input logic [31:0] cnt,
                            input logic [31:0] word);
        request_t r;
        r.op = op;
        r.idx = idx;
        r.cnt = cnt;
        r.word = word;
        pending_q.push_back(r);
    endtask

    // Random code lengths for the current bounds, mostly complete, sometimes oversubscribed
    task automatic push_code_set();
        int lo, hi;
        logic [63:0] used, room;
        logic [31:0] c;
        used = '0;
        length_bounds(sh_min, sh_max, lo, hi);
        for (int i = lo; i <= hi; i++) begin
            room = (64'h1_0000_0000 - used) >> (32 - i);
            if ($urandom_range(0, 15) == 0) c = $urandom();
            else if (i == hi) c = room[31:0];
            else c = $urandom_range(0, (room > 3) ? 3 : room[1:0]);
            used += {32'b0, c} << (32 - i);
            if (used > 64'h1_0000_0000) used = 64'h1_0000_0000;
            push_req(OP_LOAD, i[4:0], c, '0);
        end
        push_req(OP_BUILD, '0, '0, '0);
    endtask

    logic [4:0]  rmin, rmax;
    logic [31:0] rsc;
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Widest bounds, empty and oversubscribed lengths, ignored indexes
        configure(5'd1, 5'd31, 32'hFFFF_FFFF);
        push_req(OP_LOAD, 5'd0, 32'hFFFF_FFFF, '0);
        push_req(OP_LOAD, 5'd1, 32'd1, '0);
        push_req(OP_LOAD, 5'd2, 32'd0, '0);
        push_req(OP_LOAD, 5'd3, 32'd2, '0);
        push_req(OP_LOAD, 5'd5, 32'hFFFF_FFFF, '0);
        push_req(OP_LOAD, 5'd31, 32'd7, '0);
        push_req(OP_NONE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(OP_BUILD, '0, '0, '0);
        push_req(OP_STREAM, '0, '0, 32'h0000_0000);
        push_req(OP_STREAM, '0, '0, 32'hFFFF_FFFF);
        push_req(OP_STREAM, '0, '0, 32'hAAAA_AAAA);
        push_req(OP_STREAM, '0, '0, 32'h5555_5555);

        // One-bit codes: full runs of 32, symbol budget, dropped words
        configure(5'd1, 5'd1, 32'd40);
        push_req(OP_LOAD, 5'd1, 32'd2, '0);
        push_req(OP_BUILD, '0, '0, '0);
        for (int i = 0; i < 5; i++) push_req(OP_STREAM, '0, '0, $urandom());

        // Clamped bounds: zero registers, then min above max
        configure(5'd0, 5'd0, 32'd0);
        push_code_set();
        push_req(OP_STREAM, '0, '0, $urandom());
        configure(5'd20, 5'd5, 32'hFFFF_FFFF);
        push_code_set();
        push_req(OP_STREAM, '0, '0, $urandom());

        // Random phases; the config wait also drains the block fully
        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: begin rmin = 5'd31; rmax = 5'd31; end
                1: begin
                    rmin = 5'($urandom_range(1, 6));
                    rmax = 5'($urandom_range(rmin, 31));
                end
                default: begin
                    rmin = 5'($urandom_range(1, 8));
                    rmax = 5'($urandom_range(rmin, 12));
                end
            endcase
            case ($urandom_range(0, 5))
                0: rsc = $urandom_range(0, 100);
                1: rsc = $urandom();
                default: rsc = 32'hFFFF_FFFF;
            endcase
            configure(rmin, rmax, rsc);
            push_code_set();
            for (int i = 0; i < 26; i++) begin
                case ($urandom_range(0, 19))
                    0: push_req(OP_NONE, 5'($urandom()), $urandom(), $urandom());
                    1: push_req(OP_LOAD, 5'($urandom()), $urandom(), $urandom());
                    default: push_req(OP_STREAM, 5'($urandom()), $urandom(), $urandom());
                endcase
            end
        end

        wait_idle();
        if (errors == 0) $display("tb_canonical_huffman_decoder: clean");
        else $display("tb_canonical_huffman_decoder: errors");
        $finish;
    end

endmodule
